// File: src/gbn_pkg.sv
// Shared types and constants for the greedy box suppression block.
package gbn_pkg;

  localparam int unsigned CoordW      = 16;
  localparam int unsigned SizeW       = 15;
  localparam int unsigned AreaW       = 2 * SizeW;
  localparam int unsigned UnionW      = AreaW + 1;
  localparam int unsigned ThreshW     = 17;
  localparam int unsigned FracShift   = 16;
  localparam int unsigned ProdW       = ThreshW + UnionW;
  localparam int unsigned IndexW      = 12;
  localparam int unsigned MaxKeptDef  = 64;
  localparam int unsigned MaxBoxesDef = 4096;

  localparam logic [ThreshW-1:0] ThreshReset = 17'd29491;

  typedef struct packed {
    logic [SizeW-1:0]  h;
    logic [SizeW-1:0]  w;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } box_t;

  localparam int unsigned BoxW = $bits(box_t);

  typedef struct packed {
    logic              first;
    logic [CoordW-1:0] box_x;
    logic [CoordW-1:0] box_y;
    logic [SizeW-1:0]  box_w;
    logic [SizeW-1:0]  box_h;
  } in_item_t;

  typedef struct packed {
    logic              keep;
    logic [IndexW-1:0] box_index;
    logic              store_full;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic suppress;
  } iou_res_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

endpackage

// File: src/gbn_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gbn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/gbn_iou.sv
// Pipelined overlap test of the current box against one stored box per cycle.
module gbn_iou (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  gbn_pkg::box_t                     stored_i,
  input  gbn_pkg::box_t                     cur_i,
  input  logic [gbn_pkg::AreaW-1:0]         area_a_i,
  input  logic [gbn_pkg::ThreshW-1:0]       thresh_i,
  output logic                              busy_o,
  output gbn_pkg::iou_res_t                 res_o
);

  localparam int unsigned SizeW  = gbn_pkg::SizeW;
  localparam int unsigned AreaW  = gbn_pkg::AreaW;
  localparam int unsigned UnionW = gbn_pkg::UnionW;
  localparam int unsigned ProdW  = gbn_pkg::ProdW;
  localparam int unsigned Shift  = gbn_pkg::FracShift;

  // stage 1: intersection extents
  logic signed [16:0] ax, bx, ay, by;
  logic signed [16:0] ax_end, bx_end, ay_end, by_end;
  logic signed [16:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [17:0] dx, dy;
  logic [SizeW-1:0]   iw_d, ih_d;

  logic               v1_q, v2_q, v3_q, v4_q;
  logic [SizeW-1:0]   iw_q, ih_q, bw_q, bh_q;
  logic [AreaW-1:0]   inter2_q, area_b_q;
  logic [AreaW-1:0]   inter3_q, inter4_q;
  logic [UnionW-1:0]  uni_q;
  logic [ProdW-1:0]   prod_q;
  logic               uni_nz_q;
  logic [ProdW-1:0]   inter_scaled;

  always_comb begin
    ax     = $signed({cur_i.x[15], cur_i.x});
    ay     = $signed({cur_i.y[15], cur_i.y});
    bx     = $signed({stored_i.x[15], stored_i.x});
    by     = $signed({stored_i.y[15], stored_i.y});
    ax_end = ax + $signed({2'b00, cur_i.w});
    ay_end = ay + $signed({2'b00, cur_i.h});
    bx_end = bx + $signed({2'b00, stored_i.w});
    by_end = by + $signed({2'b00, stored_i.h});
    lo_x   = (ax_end < bx_end) ? ax_end : bx_end;
    hi_x   = (ax > bx) ? ax : bx;
    lo_y   = (ay_end < by_end) ? ay_end : by_end;
    hi_y   = (ay > by) ? ay : by;
    dx     = $signed({lo_x[16], lo_x}) - $signed({hi_x[16], hi_x});
    dy     = $signed({lo_y[16], lo_y}) - $signed({hi_y[16], hi_y});
    // overlap never exceeds the narrower size, so it fits the size width
    iw_d   = (dx > 0) ? dx[SizeW-1:0] : '0;
    ih_d   = (dy > 0) ? dy[SizeW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    iw_q     <= iw_d;
    ih_q     <= ih_d;
    bw_q     <= stored_i.w;
    bh_q     <= stored_i.h;
    inter2_q <= {{SizeW{1'b0}}, iw_q} * {{SizeW{1'b0}}, ih_q};
    area_b_q <= {{SizeW{1'b0}}, bw_q} * {{SizeW{1'b0}}, bh_q};
    uni_q    <= {1'b0, area_a_i} + {1'b0, area_b_q} - {1'b0, inter2_q};
    inter3_q <= inter2_q;
    prod_q   <= {{UnionW{1'b0}}, thresh_i} * {{(ProdW-UnionW){1'b0}}, uni_q};
    uni_nz_q <= (uni_q != '0);
    inter4_q <= inter3_q;
  end

  assign inter_scaled = {{(ProdW-AreaW-Shift){1'b0}}, inter4_q, {Shift{1'b0}}};

  assign busy_o         = v1_q | v2_q | v3_q | v4_q;
  assign res_o.valid    = v4_q;
  assign res_o.suppress = uni_nz_q && (inter_scaled > prod_q);

endmodule

// File: src/greedy_box_nms.sv
// Top level: sequencer, kept-box store and overlap pipeline for greedy suppression.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------
//  input   | in_valid_i / in_stall_o   | in_item_i  (gbn_pkg::in_item_t)
//  output  | out_valid_o / out_stall_i | out_item_o (gbn_pkg::out_item_t)
//  config  | cfg_we_i                  | cfg_data_i (overlap threshold)
//
// Each item scans the store with one stored box per cycle on the memory read
// port, then passes the read and four overlap stages before its result is
// ready. A new item is taken only in idle, after the last one has finished,
// and an item finishes only when the output register is free for its result.
// Reset empties the count, restarts the box position and restores the default
// threshold; the store needs no clearing. A stalled result waits in the output
// register while the next item is scanned; only the second result waits for it.
module greedy_box_nms #(
  parameter int unsigned MaxKept  = gbn_pkg::MaxKeptDef,
  parameter int unsigned MaxBoxes = gbn_pkg::MaxBoxesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gbn_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gbn_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  logic [gbn_pkg::ThreshW-1:0] cfg_data_i
);

  localparam int unsigned CntW   = $clog2(MaxKept + 1);
  localparam int unsigned AddrW  = (MaxKept > 1) ? $clog2(MaxKept) : 1;
  localparam int unsigned PosW   = $clog2(MaxBoxes);
  localparam int unsigned IdxW   = gbn_pkg::IndexW;
  localparam int unsigned SizeW  = gbn_pkg::SizeW;
  localparam int unsigned AreaW  = gbn_pkg::AreaW;
  localparam int unsigned BoxW   = gbn_pkg::BoxW;

  gbn_pkg::state_e    state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    rd_q, rd_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               rd_valid_q;
  logic               supp_q, supp_d;
  logic [gbn_pkg::ThreshW-1:0] thresh_q;
  gbn_pkg::box_t      cur_q;
  logic [AreaW-1:0]   area_a_q;
  logic               out_valid_q, out_valid_d;
  gbn_pkg::out_item_t out_q, out_d;

  logic               accept;
  logic               issue;
  logic               finish;
  logic               keep;
  logic               full;
  logic               busy;
  gbn_pkg::iou_res_t  res;
  logic [BoxW-1:0]    rdata;
  gbn_pkg::box_t      stored;
  gbn_pkg::box_t      in_box;

  assign in_stall_o = (state_q != gbn_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign issue      = (state_q == gbn_pkg::ST_SCAN) && (rd_q < count_q);
  assign finish     = (state_q == gbn_pkg::ST_SCAN) && (rd_q == count_q) && !rd_valid_q
                      && !busy && (!out_valid_q || !out_stall_i);
  assign keep       = !supp_q;
  assign full       = keep && (count_q == CntW'(MaxKept));

  assign in_box.x = in_item_i.box_x;
  assign in_box.y = in_item_i.box_y;
  assign in_box.w = in_item_i.box_w;
  assign in_box.h = in_item_i.box_h;
  assign stored   = gbn_pkg::box_t'(rdata);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_d        = rd_q;
    pos_d       = pos_q;
    supp_d      = supp_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (res.valid && res.suppress) begin
      supp_d = 1'b1;
    end

    unique case (state_q)
      gbn_pkg::ST_IDLE: begin
        if (accept) begin
          // start a new set: empty the count and restart the box position before the scan
          if (in_item_i.first) begin
            count_d = '0;
            pos_d   = '0;
          end
          rd_d    = '0;
          supp_d  = 1'b0;
          state_d = gbn_pkg::ST_SCAN;
        end
      end
      gbn_pkg::ST_SCAN: begin
        if (issue) begin
          rd_d = rd_q + CntW'(1);
        end
        if (finish) begin
          out_valid_d          = 1'b1;
          out_d.keep           = keep;
          out_d.box_index      = IdxW'(pos_q);
          out_d.store_full     = full;
          if (keep && !full) begin
            count_d = count_q + CntW'(1);
          end
          pos_d   = (pos_q == PosW'(MaxBoxes - 1)) ? '0 : pos_q + PosW'(1);
          state_d = gbn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gbn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbn_pkg::ST_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      pos_q       <= '0;
      rd_valid_q  <= 1'b0;
      supp_q      <= 1'b0;
      out_valid_q <= 1'b0;
      thresh_q    <= gbn_pkg::ThreshReset;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      pos_q       <= pos_d;
      rd_valid_q  <= issue;
      supp_q      <= supp_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thresh_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      cur_q    <= in_box;
      area_a_q <= {{SizeW{1'b0}}, in_item_i.box_w} * {{SizeW{1'b0}}, in_item_i.box_h};
    end
  end

  gbn_ram #(
    .Width (BoxW),
    .Depth (MaxKept)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (finish && keep && !full),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (cur_q),
    .re_i    (issue),
    .raddr_i (rd_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  gbn_iou u_iou (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rd_valid_q),
    .stored_i (stored),
    .cur_i    (cur_q),
    .area_a_i (area_a_q),
    .thresh_i (thresh_q),
    .busy_o   (busy),
    .res_o    (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: sim/greedy_box_nms_checker.sv
// Checker for greedy box suppression: predicts each result and compares it on the output channel.
`timescale 1ns / 1ps
module greedy_box_nms_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  gbn_pkg::in_item_t           in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  gbn_pkg::out_item_t          out_item_i,
  input  logic                        cfg_we_i,
  input  logic [gbn_pkg::ThreshW-1:0] cfg_data_i,
  output int unsigned                 err_count_o,
  output int unsigned                 pending_o
);

  localparam int unsigned ThreshW  = gbn_pkg::ThreshW;
  localparam int unsigned IndexW   = gbn_pkg::IndexW;
  localparam int unsigned MaxKept  = gbn_pkg::MaxKeptDef;
  localparam int unsigned MaxBoxes = gbn_pkg::MaxBoxesDef;
  localparam int unsigned ExpDepth = 8;

  gbn_pkg::box_t      kept_store [MaxKept];
  int unsigned        kept_n;
  int unsigned        box_pos;
  logic [ThreshW-1:0] iou_limit;
  gbn_pkg::out_item_t exp_fifo [ExpDepth];
  int unsigned        exp_head;
  int unsigned        exp_tail;
  int unsigned        exp_cnt;
  int unsigned        mism = 0;

  assign err_count_o = mism;

  // True when kept box b suppresses candidate a at the given IoU limit.
  function automatic logic box_suppressed(gbn_pkg::box_t a, gbn_pkg::box_t b,
                                          logic [ThreshW-1:0] lim);
    longint ax, ay, aw, ah, bx, by, bw, bh, iw, ih, inter, uni, lo, hi;
    ax = $signed(a.x);
    ay = $signed(a.y);
    aw = a.w;
    ah = a.h;
    bx = $signed(b.x);
    by = $signed(b.y);
    bw = b.w;
    bh = b.h;
    hi = (ax + aw < bx + bw) ? ax + aw : bx + bw;
    lo = (ax > bx) ? ax : bx;
    iw = hi - lo;
    hi = (ay + ah < by + bh) ? ay + ah : by + bh;
    lo = (ay > by) ? ay : by;
    ih = hi - lo;
    inter = (iw > 0 && ih > 0) ? iw * ih : 64'sd0;
    uni = aw * ah + bw * bh - inter;
    if (uni == 0) return 1'b0;
    return (inter * 65536) > (longint'(lim) * uni);
  endfunction

  // Append one predicted result; the block never holds more than a few.
  task automatic queue_result(input gbn_pkg::out_item_t res);
    if (exp_cnt == ExpDepth) begin
      $display("%0t: prediction overflow, expected at most %0d pending, actual %0d",
               $time, ExpDepth, exp_cnt + 1);
      mism++;
    end else begin
      exp_fifo[exp_tail] = res;
      exp_tail = (exp_tail + 1) % ExpDepth;
      exp_cnt++;
    end
  endtask

  task automatic predict_box(input gbn_pkg::in_item_t it);
    gbn_pkg::box_t      cand;
    logic               keep;
    gbn_pkg::out_item_t res;
    if (it.first) begin
      kept_n = 0;
      box_pos = 0;
    end
    cand = '{h: it.box_h, w: it.box_w, y: it.box_y, x: it.box_x};
    keep = 1'b1;
    for (int i = 0; i < kept_n; i++) begin
      if (box_suppressed(cand, kept_store[i], iou_limit)) keep = 1'b0;
    end
    res.keep = keep;
    res.box_index = box_pos[IndexW-1:0];
    res.store_full = 1'b0;
    if (keep) begin
      if (kept_n < MaxKept) begin
        kept_store[kept_n] = cand;
        kept_n++;
      end else begin
        res.store_full = 1'b1;
      end
    end
    queue_result(res);
    box_pos = (box_pos + 1 >= MaxBoxes) ? 0 : box_pos + 1;
  endtask

  task automatic check_result(input gbn_pkg::out_item_t got);
    gbn_pkg::out_item_t want;
    if (exp_cnt == 0) begin
      $display("%0t: unexpected result, expected none, actual keep=%0b index=%0d full=%0b",
               $time, got.keep, got.box_index, got.store_full);
      mism++;
    end else begin
      want = exp_fifo[exp_head];
      exp_head = (exp_head + 1) % ExpDepth;
      exp_cnt--;
      if (got.keep !== want.keep) begin
        $display("%0t: keep mismatch, expected %0b actual %0b", $time, want.keep, got.keep);
        mism++;
      end
      if (got.box_index !== want.box_index) begin
        $display("%0t: box_index mismatch, expected %0d actual %0d",
                 $time, want.box_index, got.box_index);
        mism++;
      end
      if (got.store_full !== want.store_full) begin
        $display("%0t: store_full mismatch, expected %0b actual %0b",
                 $time, want.store_full, got.store_full);
        mism++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_n = 0;
      box_pos = 0;
      iou_limit = gbn_pkg::ThreshReset;
      exp_head = 0;
      exp_tail = 0;
      exp_cnt = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) iou_limit = cfg_data_i;
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) predict_box(in_item_i);
      pending_o <= exp_cnt;
    end
  end

endmodule

// File: sim/greedy_box_nms_tb.sv
// Testbench top for greedy box suppression: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module greedy_box_nms_tb;

  localparam int unsigned CycleLimit = 800000;
  localparam int unsigned RoundItems = 120;
  localparam int unsigned ThreshW    = gbn_pkg::ThreshW;
  localparam int unsigned CoordW     = gbn_pkg::CoordW;
  localparam int unsigned SizeW      = gbn_pkg::SizeW;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  gbn_pkg::in_item_t  in_item = '0;
  logic               out_stall = 1'b0;
  logic               cfg_we = 1'b0;
  logic [ThreshW-1:0] cfg_data = '0;
  logic               in_stall;
  logic               out_valid;
  gbn_pkg::out_item_t out_item;
  int unsigned        err_count;
  int unsigned        pending;
  int unsigned        send_idle_pct = 19;
  int unsigned        recv_idle_pct = 48;
  int unsigned        cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  greedy_box_nms u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  greedy_box_nms_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic gbn_pkg::in_item_t mk_box(logic f, logic [CoordW-1:0] x,
                                               logic [CoordW-1:0] y,
                                               logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    gbn_pkg::in_item_t it;
    it.first = f;
    it.box_x = x;
    it.box_y = y;
    it.box_w = w;
    it.box_h = h;
    return it;
  endfunction

  // Grid slots never touch, cluster boxes overlap heavily, wild boxes cover every bit.
  function automatic gbn_pkg::in_item_t rand_box(int unsigned mode, int unsigned slot, logic f,
                                                 logic [CoordW-1:0] cx, logic [CoordW-1:0] cy);
    gbn_pkg::in_item_t it;
    if (mode < 25) begin
      it = mk_box(f, CoordW'((slot % 16) * 256 - 2048 + $urandom_range(0, 15)),
                  CoordW'((slot / 16) * 256 - 2048 + $urandom_range(0, 15)),
                  SizeW'($urandom_range(0, 240)), SizeW'($urandom_range(0, 240)));
    end else if (mode < 80 && $urandom_range(0, 9) != 0) begin
      it = mk_box(f, CoordW'(cx + $urandom_range(0, 127) - 64),
                  CoordW'(cy + $urandom_range(0, 127) - 64),
                  SizeW'($urandom_range(16, 400)), SizeW'($urandom_range(16, 400)));
    end else begin
      it = mk_box(f, CoordW'($urandom), CoordW'($urandom), SizeW'($urandom), SizeW'($urandom));
    end
    return it;
  endfunction

  function automatic logic [ThreshW-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 17'd65536;
      2:       return '1;
      3:       return gbn_pkg::ThreshReset;
      4:       return 17'd65535;
      5:       return ThreshW'($urandom_range(0, 131071));
      default: return ThreshW'($urandom_range(8192, 60000));
    endcase
  endfunction

  // Hold valid until the item is taken; an idle gap drops it first.
  task automatic send_box(input gbn_pkg::in_item_t it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [ThreshW-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    // Extreme coordinates and sizes, exact duplicate, far corner, empty box
    send_box(mk_box(1'b1, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff));
    send_box(mk_box(1'b0, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff));
    send_box(mk_box(1'b0, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff));
    send_box(mk_box(1'b0, 16'h8000, 16'h8000, 15'd0, 15'd100));
    // Zero union between two empty boxes, then partial overlaps around the limit
    send_box(mk_box(1'b1, 16'd0, 16'd0, 15'd0, 15'd0));
    send_box(mk_box(1'b0, 16'd0, 16'd0, 15'd0, 15'd0));
    send_box(mk_box(1'b0, 16'd0, 16'd0, 15'd16, 15'd16));
    send_box(mk_box(1'b0, 16'd8, 16'd0, 15'd16, 15'd16));
    send_box(mk_box(1'b0, 16'd4, 16'd0, 15'd16, 15'd16));
    // Zero limit: any overlap suppresses, touching edges do not
    write_limit('0);
    send_box(mk_box(1'b1, 16'd100, 16'd100, 15'd50, 15'd50));
    send_box(mk_box(1'b0, 16'd149, 16'd149, 15'd10, 15'd10));
    send_box(mk_box(1'b0, 16'd150, 16'd100, 15'd10, 15'd10));
    // Limits of 1.0 and above never suppress
    write_limit(17'd65536);
    send_box(mk_box(1'b1, 16'hff00, 16'h0040, 15'd300, 15'd200));
    send_box(mk_box(1'b0, 16'hff00, 16'h0040, 15'd300, 15'd200));
    write_limit('1);
    send_box(mk_box(1'b0, 16'hff00, 16'h0040, 15'd300, 15'd200));
    send_box(mk_box(1'b0, 16'hff10, 16'h0040, 15'd300, 15'd200));
    // Just below 1.0 an exact duplicate is suppressed
    write_limit(17'd65535);
    send_box(mk_box(1'b0, 16'hff00, 16'h0040, 15'd300, 15'd200));
    // First flag mid-set restarts numbering and clears the store
    write_limit(gbn_pkg::ThreshReset);
    send_box(mk_box(1'b0, 16'd5, 16'd5, 15'd40, 15'd40));
    send_box(mk_box(1'b1, 16'hff00, 16'h0040, 15'd300, 15'd200));
    send_box(mk_box(1'b0, CoordW'($urandom), CoordW'($urandom), SizeW'($urandom),
                    SizeW'($urandom)));
  endtask

  task automatic run_random(input int unsigned n_rounds);
    int unsigned       got;
    int unsigned       set_len;
    int unsigned       mode;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic              f;
    for (int unsigned r = 0; r < n_rounds; r++) begin
      write_limit(pick_limit());
      got = 0;
      while (got < RoundItems) begin
        mode = $urandom_range(0, 99);
        set_len = (mode < 25) ? $urandom_range(60, 80) : $urandom_range(1, 30);
        cx = CoordW'($urandom);
        cy = CoordW'($urandom);
        // Some sets continue the previous store without a first flag
        f = ($urandom_range(0, 7) != 0);
        for (int unsigned k = 0; k < set_len; k++) begin
          send_box(rand_box(mode, k, f && k == 0, cx, cy));
        end
        got += set_len;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(3);
    send_idle_pct = 48;
    recv_idle_pct = 19;
    run_random(3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(3);
    drain_results();
    repeat (80) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/gbn_pkg.sv
src/gbn_ram.sv
src/gbn_iou.sv
src/greedy_box_nms.sv
sim/greedy_box_nms_checker.sv
sim/greedy_box_nms_tb.sv
